FILE: hw/rtl/lzt_pkg.sv
package lzt_pkg;
    localparam int PEND_DEPTH = 256;

    typedef logic [7:0] t_byte;

    // control shared by every cell of the match chain
    typedef struct packed {
        logic load;    // copy window byte, arm alive flag
        logic step;    // advance one compare step
        logic fshift;  // move best flags one cell toward the oldest start
    } t_cell_ctl;
endpackage

FILE: hw/rtl/lzt_if.sv
interface lzt_in_if;
    logic valid;
    logic ready;
    logic action;
    logic [7:0] data_byte;
    modport source (output valid, output action, output data_byte, input ready);
    modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface lzt_out_if;
    logic valid;
    logic ready;
    logic [7:0] match_offset;
    logic [7:0] match_length;
    logic [7:0] literal;
    logic final_triple;
    logic expanded;
    modport source (output valid, output match_offset, output match_length,
                    output literal, output final_triple, output expanded, input ready);
    modport sink (input valid, input match_offset, input match_length,
                  input literal, input final_triple, input expanded, output ready);
endinterface

FILE: hw/rtl/lzt_cell.sv
module lzt_cell
    import lzt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_byte     i_load_byte,
    input  logic      i_hist_valid,
    input  t_byte     i_next_byte,
    input  logic      i_next_best,
    input  t_byte     i_probe,
    output logic      o_surv,
    output logic      o_best,
    output t_byte     o_byte
);
    t_byte r_byte;
    logic  r_alive;
    logic  r_best;

    // candidate still matches after this compare
    assign o_surv = r_alive && (r_byte == i_probe);
    assign o_best = r_best;
    assign o_byte = r_byte;

    // scan byte moves down the chain, flags follow the compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= 1'b0;
            r_best  <= 1'b0;
        end else if (i_ctl.load) begin
            r_alive <= i_hist_valid;
            r_best  <= 1'b0;
        end else if (i_ctl.step) begin
            r_alive <= o_surv;
            r_best  <= o_surv;
        end else if (i_ctl.fshift) begin
            r_best  <= i_next_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_byte <= i_load_byte;
        end else if (i_ctl.step) begin
            r_byte <= i_next_byte;
        end
    end
endmodule

FILE: hw/rtl/lz77_triple_encoder.sv
// channel | dir | beat
// i_in    | in  | action, data_byte
// o_out   | out | match_offset, match_length, literal, final_triple, expanded
//
// a push that leaves fewer than 256 bytes pending keeps the input ready
// a triple of length L is built in steps: accept, load, compare (capped), search for oldest start
//   (skipped when L is 0), shift of the L+1 consumed bytes, hand-off to the output register;
//   the cell chain steps one compare a cycle and the buffer shifts one byte a cycle
// reset (synchronous, active low) empties window, pending bytes and totals
// a finished triple waits in the output register; pushes go on meanwhile
// a second triple waits until the output register is taken
module lz77_triple_encoder
    import lzt_pkg::*;
#(
    parameter int WINDOW_SIZE = 255,
    parameter int MAX_MATCH   = 255
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lzt_in_if.sink    i_in,
    lzt_out_if.source o_out
);
    localparam int BUF_LEN = WINDOW_SIZE + PEND_DEPTH;
    localparam int BUF_W   = $clog2(BUF_LEN);
    localparam int CNT_W   = $clog2(WINDOW_SIZE + 1);

    typedef enum logic [2:0] {S_IDLE, S_START, S_MATCH, S_FIND, S_SHIFT, S_HOLD} t_state;

    t_state     r_state;
    t_byte      r_buf [BUF_LEN];
    t_byte      r_pscan [PEND_DEPTH];
    logic [7:0] r_hf;
    logic [8:0] r_pf;
    logic [31:0] r_in_total;
    logic [31:0] r_out_total;
    logic       r_drain;
    logic [7:0] r_cap;
    logic [7:0] r_j;
    logic [7:0] r_len;
    logic [7:0] r_off;
    t_byte      r_lit;
    logic [8:0] r_n;
    logic [CNT_W-1:0] r_cnt;

    logic       r_ov;
    logic [7:0] r_o_off;
    logic [7:0] r_o_len;
    t_byte      r_o_lit;
    logic       r_o_final;
    logic       r_o_exp;

    t_cell_ctl  w_ctl;
    logic [WINDOW_SIZE-1:0] w_surv;
    logic [WINDOW_SIZE-1:0] w_best;
    logic       w_any;
    logic       w_acc;
    logic [8:0] w_capx;
    logic [9:0] w_hf_sum;
    logic       w_final;
    logic [BUF_W-1:0] w_widx;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_any      = |w_surv;
    assign w_capx     = (r_pf - 9'd1 > 9'(MAX_MATCH)) ? 9'(MAX_MATCH) : r_pf - 9'd1;
    assign w_hf_sum   = 10'(r_hf) + 10'(r_len) + 10'd1;
    assign w_final    = r_drain && (r_pf == 9'd0);
    assign w_widx     = BUF_W'(WINDOW_SIZE) + BUF_W'(r_pf[7:0]);

    // chain control
    always_comb begin
        w_ctl.load   = (r_state == S_START);
        w_ctl.step   = (r_state == S_MATCH) && w_any;
        w_ctl.fshift = (r_state == S_FIND) && !w_best[0];
    end

    // one cell per window position, cell s is the start at offset WINDOW_SIZE - s
    genvar g;
    generate
        for (g = 0; g < WINDOW_SIZE; g++) begin : g_cell
            t_byte w_nb;
            logic  w_nbest;
            t_byte w_nb_out;
            if (g == WINDOW_SIZE - 1) begin : g_last
                assign w_nb    = r_pscan[0];
                assign w_nbest = 1'b0;
            end else begin : g_mid
                assign w_nb    = g_cell[g+1].w_nb_out;
                assign w_nbest = w_best[g+1];
            end
            lzt_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_load_byte  (r_buf[g]),
                .i_hist_valid (32'(g) >= 32'(WINDOW_SIZE) - 32'(r_hf)),
                .i_next_byte  (w_nb),
                .i_next_best  (w_nbest),
                .i_probe      (r_pscan[0]),
                .o_surv       (w_surv[g]),
                .o_best       (w_best[g]),
                .o_byte       (w_nb_out)
            );
        end
    endgenerate

    // pending part of the scan line, probe byte at its head
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PEND_DEPTH; k++) begin
            if (w_ctl.load) begin
                r_pscan[k] <= r_buf[WINDOW_SIZE + k];
            end else if (w_ctl.step) begin
                r_pscan[k] <= (k == PEND_DEPTH - 1) ? 8'd0 : r_pscan[k+1];
            end
        end
    end

    // window followed by pending bytes, shifted one byte a cycle on commit
    always_ff @(posedge i_clk) begin
        if (r_state == S_SHIFT) begin
            for (int k = 0; k < BUF_LEN; k++) begin
                r_buf[k] <= (k == BUF_LEN - 1) ? 8'd0 : r_buf[k+1];
            end
        end else if (w_acc && !i_in.action) begin
            r_buf[w_widx] <= i_in.data_byte;
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hf        <= '0;
            r_pf        <= '0;
            r_in_total  <= '0;
            r_out_total <= '0;
            r_drain     <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (o_out.ready && (r_state != S_HOLD)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (!i_in.action) begin
                            r_pf       <= r_pf + 9'd1;
                            r_in_total <= r_in_total + 32'd1;
                            r_drain    <= 1'b0;
                            if (r_pf == 9'(PEND_DEPTH - 1)) begin
                                r_state <= S_START;
                            end
                        end else if (r_pf != 9'd0) begin
                            r_drain <= 1'b1;
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_cap <= w_capx[7:0];
                    r_j   <= '0;
                    r_off <= '0;
                    r_cnt <= '0;
                    if (w_capx == 9'd0) begin
                        r_len   <= '0;
                        r_lit   <= r_buf[WINDOW_SIZE];
                        r_n     <= 9'd1;
                        r_state <= S_SHIFT;
                    end else begin
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    if (w_any) begin
                        r_j <= r_j + 8'd1;
                        if (r_j + 8'd1 == r_cap) begin
                            r_len   <= r_cap;
                            r_lit   <= r_pscan[1];
                            r_n     <= 9'(r_cap) + 9'd1;
                            r_state <= S_FIND;
                        end
                    end else begin
                        r_len   <= r_j;
                        r_lit   <= r_pscan[0];
                        r_n     <= 9'(r_j) + 9'd1;
                        r_state <= (r_j == 8'd0) ? S_SHIFT : S_FIND;
                    end
                end
                S_FIND: begin
                    if (w_best[0]) begin
                        r_off   <= 8'(WINDOW_SIZE - 32'(r_cnt));
                        r_state <= S_SHIFT;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_SHIFT: begin
                    r_n <= r_n - 9'd1;
                    if (r_n == 9'd1) begin
                        r_hf <= (w_hf_sum > 10'(WINDOW_SIZE)) ? 8'(WINDOW_SIZE)
                                                              : w_hf_sum[7:0];
                        r_pf        <= r_pf - (9'(r_len) + 9'd1);
                        r_out_total <= r_out_total + 32'd3;
                        r_state     <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov      <= 1'b1;
                        r_o_off   <= r_off;
                        r_o_len   <= r_len;
                        r_o_lit   <= r_lit;
                        r_o_final <= w_final;
                        r_o_exp   <= w_final && (r_out_total > r_in_total);
                        if (w_final) begin
                            r_hf        <= '0;
                            r_in_total  <= '0;
                            r_out_total <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.match_offset = r_o_off;
    assign o_out.match_length = r_o_len;
    assign o_out.literal      = r_o_lit;
    assign o_out.final_triple = r_o_final;
    assign o_out.expanded     = r_o_exp;

    // checks
    a_pf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pf <= 9'(PEND_DEPTH)) else $error("pending count overflow");
    a_hf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hf <= 8'(WINDOW_SIZE)) else $error("window fill overflow");
    a_exp_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.expanded |-> o_out.final_triple)
        else $error("expanded without final triple");
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.match_length == 8'd0) |-> (o_out.match_offset == 8'd0))
        else $error("offset on empty match");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MATCH) |-> !i_in.ready) else $error("input taken during match");
endmodule
